[hw/rtl/rgb_convolution_mirror_border_unit_assert.svh]
// assertion macros shared by the convolution unit rtl
// expects clk and rst_n in the scope of each use
`ifndef RGB_CONVOLUTION_MIRROR_BORDER_UNIT_ASSERT_SVH
`define RGB_CONVOLUTION_MIRROR_BORDER_UNIT_ASSERT_SVH

// property that must hold at every clock edge outside reset
`define RCMB_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// trigger at one edge implies consequence at the next edge
`define RCMB_ASSERT_NEXT(label, trig, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/rcmb_pkg.sv]
// shared types, constants and helpers of the 3x3 rgb convolution unit
// no dependencies
package rcmb_pkg;

    localparam int MAX_WIDTH_DEF  = 2048;
    localparam int MAX_HEIGHT_DEF = 2048;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 63;
    localparam int DIM_W      = 12;
    localparam int CNT_W      = 11;
    localparam int COEF_W     = 21;
    localparam int CH_W       = 8;
    localparam int PIX_W      = 3 * CH_W;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_TOP     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_MIDDLE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_BOTTOM  = 3'd4;

    localparam logic [DIM_W-1:0]      WIDTH_RST  = 12'd640;
    localparam logic [DIM_W-1:0]      HEIGHT_RST = 12'd480;
    localparam logic [CFG_DATA_W-1:0] COEF_MID_RST = 63'd20971520000;

    localparam int NUM_LANES = 4;
    localparam int LANE_LAT  = 4;
    localparam int QDEPTH    = 16;

    // truncating divide by 10000 of a value below 2560000:
    // q = (s * RECIP) >> RECIP_SHIFT is exact over that range
    localparam int                SAT_LIMIT   = 2560000;
    localparam int                FRAC_W      = 22;
    localparam logic [22:0]       RECIP       = 23'd6871948;
    localparam int                RECIP_SHIFT = 36;

    // window row / column selector
    typedef logic [1:0] win_sel_t;
    localparam win_sel_t SEL_FAR  = 2'd0;
    localparam win_sel_t SEL_MID  = 2'd1;
    localparam win_sel_t SEL_NEAR = 2'd2;

    typedef logic [PIX_W-1:0] pixel_t;
    typedef pixel_t [2:0][2:0] window_t;   // [row][col], 2 is newest

    typedef struct packed {
        logic              valid;
        win_sel_t [2:0]    rsel;   // window row for each kernel row
        win_sel_t [2:0]    csel;   // window column for each kernel column
    } lane_ctrl_t;

    typedef struct packed {
        logic [CH_W-1:0] blue;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] red;
        logic            last;
        logic            eof;
    } result_t;

    function automatic logic signed [COEF_W-1:0] coef_at(input logic [CFG_DATA_W-1:0] row,
                                                         input int col);
        return $signed(row[COEF_W*col +: COEF_W]);
    endfunction

endpackage

[hw/rtl/rcmb_ram.sv]
// generic single write port ram with registered read
// no dependencies
module rcmb_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[hw/rtl/rcmb_lane.sv]
// one convolution lane: 27 products, adder tree, divide by 10000 and clamp
// depends on rcmb_pkg
module rcmb_lane
    import rcmb_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  lane_ctrl_t            ctrl,
    input  window_t               win,
    input  logic [CFG_DATA_W-1:0] coef_top,
    input  logic [CFG_DATA_W-1:0] coef_mid,
    input  logic [CFG_DATA_W-1:0] coef_bot,
    output logic                  res_valid,
    output pixel_t                res_pix
);

    function automatic logic [CH_W-1:0] pick(input window_t w, input win_sel_t r,
                                             input win_sel_t c, input int ch);
        pixel_t row0;
        pixel_t row1;
        pixel_t row2;
        pixel_t sel;
        row0 = w[0][0];
        row1 = w[0][1];
        row2 = w[0][2];
        case (r)
            SEL_FAR:  begin row0 = w[0][0]; row1 = w[0][1]; row2 = w[0][2]; end
            SEL_MID:  begin row0 = w[1][0]; row1 = w[1][1]; row2 = w[1][2]; end
            SEL_NEAR: begin row0 = w[2][0]; row1 = w[2][1]; row2 = w[2][2]; end
            default:  begin row0 = w[0][0]; row1 = w[0][1]; row2 = w[0][2]; end
        endcase
        case (c)
            SEL_FAR:  sel = row0;
            SEL_MID:  sel = row1;
            SEL_NEAR: sel = row2;
            default:  sel = row0;
        endcase
        return sel[CH_W*ch +: CH_W];
    endfunction

    logic [LANE_LAT-1:0] v_reg;

    logic signed [29:0]        prod_reg [3][3][3];   // [ch][krow][kcol]
    logic signed [31:0]        rsum_reg [3][3];      // [ch][krow]
    logic                      neg_reg  [3];
    logic                      sat_reg  [3];
    logic [FRAC_W-1:0]         frac_reg [3];
    logic                      neg2_reg [3];
    logic                      sat2_reg [3];
    logic [FRAC_W+22:0]        mul_reg  [3];

    logic [CFG_DATA_W-1:0]     rows [3];
    logic signed [33:0]        total [3];

    assign rows[0] = coef_top;
    assign rows[1] = coef_mid;
    assign rows[2] = coef_bot;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= {v_reg[LANE_LAT-2:0], ctrl.valid};
        end
    end

    // products, one per channel and kernel tap
    always_ff @(posedge clk)
    begin
        for (int ch = 0; ch < 3; ch++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    prod_reg[ch][i][j] <=
                        $signed({1'b0, pick(win, ctrl.rsel[i], ctrl.csel[j], ch)})
                        * coef_at(rows[i], j);
                end
            end
        end
    end

    // kernel row sums
    always_ff @(posedge clk)
    begin
        for (int ch = 0; ch < 3; ch++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                rsum_reg[ch][i] <= 32'(prod_reg[ch][i][0]) + 32'(prod_reg[ch][i][1])
                                 + 32'(prod_reg[ch][i][2]);
            end
        end
    end

    always_comb
    begin
        for (int ch = 0; ch < 3; ch++)
        begin
            total[ch] = 34'(rsum_reg[ch][0]) + 34'(rsum_reg[ch][1]) + 34'(rsum_reg[ch][2]);
        end
    end

    // negative sums clamp to zero, sums of 256*10000 and more clamp to 255
    always_ff @(posedge clk)
    begin
        for (int ch = 0; ch < 3; ch++)
        begin
            neg_reg[ch]  <= total[ch] < 0;
            sat_reg[ch]  <= total[ch] >= 34'(SAT_LIMIT);
            frac_reg[ch] <= total[ch][FRAC_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int ch = 0; ch < 3; ch++)
        begin
            neg2_reg[ch] <= neg_reg[ch];
            sat2_reg[ch] <= sat_reg[ch];
            mul_reg[ch]  <= 45'(frac_reg[ch]) * 45'(RECIP);
        end
    end

    always_comb
    begin
        for (int ch = 0; ch < 3; ch++)
        begin
            if (neg2_reg[ch])
            begin
                res_pix[CH_W*ch +: CH_W] = '0;
            end
            else if (sat2_reg[ch])
            begin
                res_pix[CH_W*ch +: CH_W] = '1;
            end
            else
            begin
                res_pix[CH_W*ch +: CH_W] = mul_reg[ch][RECIP_SHIFT +: CH_W];
            end
        end
    end

    assign res_valid = v_reg[LANE_LAT-1];

endmodule

[hw/rtl/rcmb_outq.sv]
// merge of the lane results into a result queue, up to four pushes a cycle
// depends on rcmb_pkg and the assertion macro header
module rcmb_outq
    import rcmb_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [NUM_LANES-1:0] push_valid,
    input  pixel_t               push_pix [NUM_LANES],
    input  logic                 push_eof,
    input  logic                 pop,
    output logic                 res_valid,
    output result_t              res
);

`include "rgb_convolution_mirror_border_unit_assert.svh"

    localparam int PW = $clog2(QDEPTH);

    result_t         q_reg [QDEPTH];
    logic [PW-1:0]   head_reg;
    logic [PW:0]     count_reg;

    logic [PW-1:0]   slot   [NUM_LANES];
    logic            is_last[NUM_LANES];
    logic [PW:0]     push_n;

    always_comb
    begin
        logic [PW:0] offs;
        offs = '0;
        for (int i = 0; i < NUM_LANES; i++)
        begin
            slot[i]    = PW'(head_reg + count_reg[PW-1:0] + offs[PW-1:0]);
            is_last[i] = 1'b1;
            for (int k = i + 1; k < NUM_LANES; k++)
            begin
                if (push_valid[k])
                begin
                    is_last[i] = 1'b0;
                end
            end
            if (push_valid[i])
            begin
                offs = offs + 1'b1;
            end
        end
        push_n = offs;
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NUM_LANES; i++)
        begin
            if (push_valid[i])
            begin
                q_reg[slot[i]] <= '{blue:  push_pix[i][2*CH_W +: CH_W],
                                    green: push_pix[i][CH_W +: CH_W],
                                    red:   push_pix[i][0 +: CH_W],
                                    last:  is_last[i],
                                    eof:   is_last[i] & push_eof};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (pop)
            begin
                head_reg <= head_reg + 1'b1;
            end
            count_reg <= count_reg + push_n - {{PW{1'b0}}, pop};
        end
    end

    assign res_valid = count_reg != '0;
    assign res       = q_reg[head_reg];

    `RCMB_ASSERT(a_q_bound, count_reg <= (PW+1)'(QDEPTH), "result queue overflow")
    `RCMB_ASSERT(a_q_room, 32'(count_reg) + 32'(push_n) <= QDEPTH + 32'(pop), "push into full queue")
    `RCMB_ASSERT_NEXT(a_q_drain, pop && push_n == '0, count_reg == $past(count_reg) - 1'b1, "pop miscounted")

endmodule

[hw/rtl/rgb_convolution_mirror_border_unit.sv]
// top level of the 3x3 rgb convolution unit with mirrored borders
// depends on rcmb_pkg, rcmb_ram, rcmb_lane, rcmb_outq and the assertion macro header

// Streams RGB pixels in raster order and returns 3x3 filtered pixels in raster
// order, one row and one column behind the input. Each channel is the sum of
// the nine window pixels times signed 21-bit coefficients (scale 10000),
// divided by 10000 toward zero and clamped to 0..255; borders mirror (index -1
// reads 1, index W reads W-1). One pixel is taken per clock while in_ready is
// high. Each pixel yields zero to four results; results leave at most one per
// clock, so on the last row (two results per pixel) the output port sets the
// pace, and row-end bursts are absorbed by a 16-entry result queue. in_ready
// drops only when the queue plus the results still in the pipeline leave no
// room for a four-result burst. Four convolution lanes, one per result slot,
// compute all results of one pixel side by side. The line stores are two
// single-port-write rams, read at the accept edge; no clearing pass after
// reset. Configuration must be written only while the stream is idle; the
// block itself does not enforce it.
module rgb_convolution_mirror_border_unit
    import rcmb_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration write channel
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // pixel input channel
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [CH_W-1:0]       in_red,
    input  logic [CH_W-1:0]       in_green,
    input  logic [CH_W-1:0]       in_blue,
    // result channel
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [CH_W-1:0]       out_red,
    output logic [CH_W-1:0]       out_green,
    output logic [CH_W-1:0]       out_blue,
    output logic                  last_of_run,
    output logic                  end_of_frame
);

`include "rgb_convolution_mirror_border_unit_assert.svh"

    localparam int AW  = $clog2(MAX_WIDTH);
    localparam int WCW = $clog2(MAX_WIDTH + 1);
    localparam int HCW = $clog2(MAX_HEIGHT + 1);
    localparam int QW  = $clog2(QDEPTH + 1);

    // configuration registers
    logic [DIM_W-1:0]      img_w_reg;
    logic [DIM_W-1:0]      img_h_reg;
    logic [CFG_DATA_W-1:0] coef_top_reg;
    logic [CFG_DATA_W-1:0] coef_mid_reg;
    logic [CFG_DATA_W-1:0] coef_bot_reg;

    // raster position
    logic [CNT_W-1:0] col_cnt_reg;
    logic [CNT_W-1:0] row_cnt_reg;

    // stage 1: accepted pixel waits for the line store read
    logic                 s1_valid_reg;
    lane_ctrl_t           s1_ctrl_reg [NUM_LANES];
    logic                 s1_eof_reg;
    pixel_t               s1_pix_reg;
    logic [AW-1:0]        s1_idx_reg;

    // stage 2: window holds the item, lanes start
    window_t              win_reg;
    lane_ctrl_t           s2_ctrl_reg [NUM_LANES];
    logic [LANE_LAT:0]    eof_pipe_reg;

    // results committed to the queue or still in flight
    logic [QW-1:0]        pending_reg;

    logic                 accept;
    logic                 pop;
    logic [WCW-1:0]       w_eff;
    logic [HCW-1:0]       h_eff;
    logic                 row_end;
    logic                 last_row;
    logic                 y_pos;
    logic                 x_pos;
    logic [AW-1:0]        idx;
    lane_ctrl_t           ctrl [NUM_LANES];
    logic [NUM_LANES-1:0] lane_on;
    logic [2:0]           n_res;
    pixel_t               older_rd;
    pixel_t               newer_rd;
    logic [NUM_LANES-1:0] lane_valid;
    pixel_t               lane_pix [NUM_LANES];
    logic                 q_valid;
    result_t              q_res;
    logic                 lane_order_ok;

    assign cfg_ready = 1'b1;
    assign accept    = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            img_w_reg    <= WIDTH_RST;
            img_h_reg    <= HEIGHT_RST;
            coef_top_reg <= '0;
            coef_mid_reg <= COEF_MID_RST;
            coef_bot_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_IMAGE_WIDTH:  img_w_reg    <= cfg_data[DIM_W-1:0];
                REG_IMAGE_HEIGHT: img_h_reg    <= cfg_data[DIM_W-1:0];
                REG_COEF_TOP:     coef_top_reg <= cfg_data;
                REG_COEF_MIDDLE:  coef_mid_reg <= cfg_data;
                REG_COEF_BOTTOM:  coef_bot_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    // frame size clamped to the supported range
    always_comb
    begin
        if (img_w_reg < DIM_W'(2))
        begin
            w_eff = WCW'(2);
        end
        else if (32'(img_w_reg) > MAX_WIDTH)
        begin
            w_eff = WCW'(MAX_WIDTH);
        end
        else
        begin
            w_eff = WCW'(img_w_reg);
        end
        if (img_h_reg < DIM_W'(2))
        begin
            h_eff = HCW'(2);
        end
        else if (32'(img_h_reg) > MAX_HEIGHT)
        begin
            h_eff = HCW'(MAX_HEIGHT);
        end
        else
        begin
            h_eff = HCW'(img_h_reg);
        end
    end

    // counts past the edge (size shrunk mid-frame) still end the row / frame
    assign row_end  = 32'(col_cnt_reg) >= 32'(w_eff) - 32'd1;
    assign last_row = 32'(row_cnt_reg) >= 32'(h_eff) - 32'd1;
    assign y_pos    = row_cnt_reg != '0;
    assign x_pos    = col_cnt_reg != '0;
    assign idx      = (32'(col_cnt_reg) < MAX_WIDTH) ? AW'(col_cnt_reg) : AW'(MAX_WIDTH - 1);

    // result slots in output order: first column upper/lower row, then the
    // mirrored right-edge column upper/lower row
    always_comb
    begin
        win_sel_t [2:0] upper;
        win_sel_t [2:0] lower;
        win_sel_t [2:0] col_a;
        win_sel_t [2:0] col_b;
        win_sel_t [2:0] col_first;
        logic           has_first;
        logic           has_second;

        // top row of the frame mirrors row 1 into row -1
        upper[0] = (row_cnt_reg == CNT_W'(1)) ? SEL_NEAR : SEL_FAR;
        upper[1] = SEL_MID;
        upper[2] = SEL_NEAR;
        // bottom row of the frame mirrors onto itself
        lower[0] = SEL_MID;
        lower[1] = SEL_NEAR;
        lower[2] = SEL_NEAR;
        // left column mirrors column 1 into column -1
        col_a[0] = (col_cnt_reg == CNT_W'(1)) ? SEL_NEAR : SEL_FAR;
        col_a[1] = SEL_MID;
        col_a[2] = SEL_NEAR;
        // right edge column mirrors onto itself
        col_b[0] = SEL_MID;
        col_b[1] = SEL_NEAR;
        col_b[2] = SEL_NEAR;

        has_first  = x_pos || row_end;
        has_second = x_pos && row_end;
        col_first  = x_pos ? col_a : col_b;

        lane_on[0] = has_first && y_pos;
        lane_on[1] = has_first && last_row;
        lane_on[2] = has_second && y_pos;
        lane_on[3] = has_second && last_row;

        ctrl[0] = '{valid: lane_on[0], rsel: upper, csel: col_first};
        ctrl[1] = '{valid: lane_on[1], rsel: lower, csel: col_first};
        ctrl[2] = '{valid: lane_on[2], rsel: upper, csel: col_b};
        ctrl[3] = '{valid: lane_on[3], rsel: lower, csel: col_b};

        n_res = 3'($countones(lane_on));
    end

    // line stores: older holds row y-2, newer row y-1
    rcmb_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_older (
        .clk   (clk),
        .we    (s1_valid_reg),
        .waddr (s1_idx_reg),
        .wdata (newer_rd),
        .re    (accept),
        .raddr (idx),
        .rdata (older_rd)
    );

    rcmb_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_newer (
        .clk   (clk),
        .we    (s1_valid_reg),
        .waddr (s1_idx_reg),
        .wdata (s1_pix_reg),
        .re    (accept),
        .raddr (idx),
        .rdata (newer_rd)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_cnt_reg  <= '0;
            row_cnt_reg  <= '0;
            s1_valid_reg <= 1'b0;
            pending_reg  <= '0;
            eof_pipe_reg <= '0;
            win_reg      <= '0;
            for (int i = 0; i < NUM_LANES; i++)
            begin
                s1_ctrl_reg[i] <= '0;
                s2_ctrl_reg[i] <= '0;
            end
        end
        else
        begin
            if (accept)
            begin
                if (row_end)
                begin
                    col_cnt_reg <= '0;
                    row_cnt_reg <= last_row ? '0 : row_cnt_reg + 1'b1;
                end
                else
                begin
                    col_cnt_reg <= col_cnt_reg + 1'b1;
                end
            end
            s1_valid_reg <= accept;
            for (int i = 0; i < NUM_LANES; i++)
            begin
                s1_ctrl_reg[i] <= '{valid: accept && lane_on[i],
                                    rsel:  ctrl[i].rsel,
                                    csel:  ctrl[i].csel};
                s2_ctrl_reg[i] <= s1_ctrl_reg[i];
            end
            eof_pipe_reg <= {eof_pipe_reg[LANE_LAT-1:0], s1_eof_reg};

            // window shifts left, new column from the line stores and the pixel
            if (s1_valid_reg)
            begin
                for (int r = 0; r < 3; r++)
                begin
                    win_reg[r][0] <= win_reg[r][1];
                    win_reg[r][1] <= win_reg[r][2];
                end
                win_reg[0][2] <= older_rd;
                win_reg[1][2] <= newer_rd;
                win_reg[2][2] <= s1_pix_reg;
            end

            pending_reg <= pending_reg + (accept ? QW'(n_res) : QW'(0)) - QW'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pix_reg <= {in_blue, in_green, in_red};
            s1_idx_reg <= idx;
            s1_eof_reg <= row_end && last_row;
        end
    end

    // room for a full burst on top of everything already promised
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ready <= 1'b0;
        end
        else
        begin
            in_ready <= 32'(pending_reg + (accept ? QW'(n_res) : QW'(0)) - QW'(pop))
                        <= QDEPTH - NUM_LANES;
        end
    end

    for (genvar g = 0; g < NUM_LANES; g++)
    begin : g_lane
        rcmb_lane u_lane (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (s2_ctrl_reg[g]),
            .win       (win_reg),
            .coef_top  (coef_top_reg),
            .coef_mid  (coef_mid_reg),
            .coef_bot  (coef_bot_reg),
            .res_valid (lane_valid[g]),
            .res_pix   (lane_pix[g])
        );
    end

    rcmb_outq u_outq (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (lane_valid),
        .push_pix   (lane_pix),
        .push_eof   (eof_pipe_reg[LANE_LAT]),
        .pop        (pop),
        .res_valid  (q_valid),
        .res        (q_res)
    );

    assign out_valid    = q_valid;
    assign out_red      = q_res.red;
    assign out_green    = q_res.green;
    assign out_blue     = q_res.blue;
    assign last_of_run  = q_res.last;
    assign end_of_frame = q_res.eof;

    // a lower-row slot is only ever used together with its upper-row slot
    assign lane_order_ok = (!s2_ctrl_reg[1].valid || s2_ctrl_reg[0].valid)
                        && (!s2_ctrl_reg[3].valid || s2_ctrl_reg[2].valid);

    `RCMB_ASSERT(a_pending_bound, 32'(pending_reg) <= QDEPTH, "result credit overrun")
    `RCMB_ASSERT_NEXT(a_row_wrap, accept && row_end, col_cnt_reg == '0, "row end not wrapped")
    `RCMB_ASSERT(a_lane_order, lane_order_ok, "lower slot without upper slot")
    `RCMB_ASSERT(a_eof_last, !out_valid || !end_of_frame || last_of_run, "frame end not last")

endmodule
